/* rtl/q2e_pkg.sv */
// package for the quaternion to euler angle converter: types, constants, angle table
`timescale 1ns / 1ps
package q2e_pkg;

   localparam int CordicStagesDefault = 16;
   localparam int CordicStagesMax = 32;

   // 36 bits hold every product, sum and cordic value including gain
   localparam int DataWidth = 36;
   localparam int AngleWidth = 32;
   localparam int SqrtInWidth = 58;
   localparam int SqrtRootWidth = 29;

   typedef struct packed {
      logic signed [15:0] quat_w;
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic pitch_clamped;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] x;
      logic signed [DataWidth-1:0] y;
      logic [AngleWidth-1:0] z;
   } cordic_vec_type;

   function automatic logic [AngleWidth-1:0] angle_table(input logic [4:0] idx);
      logic [AngleWidth-1:0] r;
      unique case (idx)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         5'd24: r = 32'd41;
         5'd25: r = 32'd20;
         5'd26: r = 32'd10;
         5'd27: r = 32'd5;
         5'd28: r = 32'd3;
         5'd29: r = 32'd1;
         5'd30: r = 32'd1;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] to_angle16(input logic [AngleWidth-1:0] z);
      logic [AngleWidth-1:0] t;
      t = z + 32'h0000_8000;
      return t[31:16];
   endfunction

endpackage

/* rtl/quaternion_to_euler_angles.sv */
// top level: quaternion to roll, pitch and yaw binary angles
//
// one transaction on req_ carries a Q1.14 quaternion; one transaction on rsp_
// carries roll, pitch and yaw (32768 = pi) and the pitch clamp flag.
// the datapath is a pipeline that takes one transaction per cycle unless stalled:
//   stage 1 products, stage 2 sums, stage 3 s squared, stage 4 remainder,
//   29 square root stages, one prescale stage, CORDIC_STAGES cordic stages
//   and the output register.
// throughput one transaction per clock while rsp_stall does not hold the output.
// roll and yaw travel alongside the square root in delay registers.
// a stall on rsp_stall freezes the whole pipeline; req_stall follows it only
// while the output holds a result, so no transaction is lost or repeated.
// synchronous reset clears the valid bits; payload registers are not reset.
`timescale 1ns / 1ps
module quaternion_to_euler_angles #(
   parameter int CORDIC_STAGES = q2e_pkg::CordicStagesDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  q2e_pkg::req_payload_type req_payload,
   output logic rsp_valid,
   input  logic rsp_stall,
   output q2e_pkg::rsp_payload_type rsp_payload
);

   localparam int W = q2e_pkg::DataWidth;
   localparam int Sq = q2e_pkg::SqrtRootWidth;
   localparam int Pre = 4 + Sq;
   localparam int Depth = Pre + 2 + CORDIC_STAGES;
   localparam logic signed [W-1:0] One = W'(64'sd1 << 28);

   logic enable;
   logic [Depth-1:0] valid_ff;
   logic [Depth-1:0] valid_in;

   assign enable = !(rsp_valid && rsp_stall);
   assign req_stall = !enable;

   always_comb begin
      valid_in = {valid_ff[Depth-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // stage 1: products
   logic signed [31:0] p_wx_ff, p_yz_ff, p_xx_ff, p_yy_ff, p_wz_ff, p_xy_ff,
                       p_zz_ff, p_wy_ff, p_zx_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         p_wx_ff <= req_payload.quat_w * req_payload.quat_x;
         p_yz_ff <= req_payload.quat_y * req_payload.quat_z;
         p_xx_ff <= req_payload.quat_x * req_payload.quat_x;
         p_yy_ff <= req_payload.quat_y * req_payload.quat_y;
         p_wz_ff <= req_payload.quat_w * req_payload.quat_z;
         p_xy_ff <= req_payload.quat_x * req_payload.quat_y;
         p_zz_ff <= req_payload.quat_z * req_payload.quat_z;
         p_wy_ff <= req_payload.quat_w * req_payload.quat_y;
         p_zx_ff <= req_payload.quat_z * req_payload.quat_x;
      end
   end

   // stage 2: sums
   logic signed [W-1:0] sr_ff, cr_ff, sy_ff, cy_ff, s_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         sr_ff <= (W'(p_wx_ff) + W'(p_yz_ff)) <<< 1;
         cr_ff <= One - ((W'(p_xx_ff) + W'(p_yy_ff)) <<< 1);
         sy_ff <= (W'(p_wz_ff) + W'(p_xy_ff)) <<< 1;
         cy_ff <= One - ((W'(p_yy_ff) + W'(p_zz_ff)) <<< 1);
         s_ff <= (W'(p_wy_ff) - W'(p_zx_ff)) <<< 1;
      end
   end

   // stage 3: |s| squared as 15x15 partial products, plus clamp decision
   logic [29:0] s_mag;
   logic [29:0] sq_hi_ff;
   logic [29:0] sq_lo_ff;
   logic [29:0] s_mag_ff;
   logic signed [W-1:0] s3_ff;
   logic clamp3_ff, neg3_ff;
   logic signed [W-1:0] sr3_ff, cr3_ff, sy3_ff, cy3_ff;
   always_comb begin
      s_mag = s_ff[W-1] ? 30'(-s_ff) : 30'(s_ff);
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         s_mag_ff <= s_mag;
         sq_hi_ff <= 30'(s_mag[29:15]) * 30'(s_mag[29:15]);
         sq_lo_ff <= 30'(s_mag[14:0]) * 30'(s_mag[14:0]);
         s3_ff <= s_ff;
         clamp3_ff <= (s_ff >= One) || (s_ff <= -One);
         neg3_ff <= s_ff[W-1];
         sr3_ff <= sr_ff;
         cr3_ff <= cr_ff;
         sy3_ff <= sy_ff;
         cy3_ff <= cy_ff;
      end
   end

   // stage 4: finish square and remainder 2^56 - s^2 (clamped items give junk)
   logic [59:0] sq_full;
   logic [q2e_pkg::SqrtInWidth-1:0] rem4_ff;
   logic signed [W-1:0] s4_ff;
   logic clamp4_ff, neg4_ff;
   logic signed [W-1:0] sr4_ff, cr4_ff, sy4_ff, cy4_ff;
   always_comb begin
      sq_full = (60'(sq_hi_ff) << 30) + (60'(sq_lo_ff))
              + (60'(30'(s_mag_ff[29:15]) * 30'(s_mag_ff[14:0])) << 16);
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         rem4_ff <= q2e_pkg::SqrtInWidth'((60'd1 << 56) - sq_full);
         s4_ff <= s3_ff;
         clamp4_ff <= clamp3_ff;
         neg4_ff <= neg3_ff;
         sr4_ff <= sr3_ff;
         cr4_ff <= cr3_ff;
         sy4_ff <= sy3_ff;
         cy4_ff <= cy3_ff;
      end
   end

   // square root chain with side delay lines
   logic [q2e_pkg::SqrtInWidth-1:0] rem_c [Sq+1];
   logic [Sq-1:0] root_c [Sq+1];
   logic signed [W-1:0] s_d_ff [Sq];
   logic clamp_d_ff [Sq];
   logic neg_d_ff [Sq];
   logic signed [W-1:0] sr_d_ff [Sq];
   logic signed [W-1:0] cr_d_ff [Sq];
   logic signed [W-1:0] sy_d_ff [Sq];
   logic signed [W-1:0] cy_d_ff [Sq];
   assign rem_c[0] = rem4_ff;
   assign root_c[0] = '0;

   for (genvar k = 0; k < Sq; k++) begin : g_sqrt
      q2e_sqrt_stage #(.STEP(k)) u_step (
         .clock(clock),
         .enable(enable),
         .rem_in(rem_c[k]),
         .root_in(root_c[k]),
         .rem_out(rem_c[k+1]),
         .root_out(root_c[k+1])
      );
      always_ff @(posedge clock) begin
         if (enable) begin
            if (k == 0) begin
               s_d_ff[k] <= s4_ff;
               clamp_d_ff[k] <= clamp4_ff;
               neg_d_ff[k] <= neg4_ff;
               sr_d_ff[k] <= sr4_ff;
               cr_d_ff[k] <= cr4_ff;
               sy_d_ff[k] <= sy4_ff;
               cy_d_ff[k] <= cy4_ff;
            end else begin
               s_d_ff[k] <= s_d_ff[k-1];
               clamp_d_ff[k] <= clamp_d_ff[k-1];
               neg_d_ff[k] <= neg_d_ff[k-1];
               sr_d_ff[k] <= sr_d_ff[k-1];
               cr_d_ff[k] <= cr_d_ff[k-1];
               sy_d_ff[k] <= sy_d_ff[k-1];
               cy_d_ff[k] <= cy_d_ff[k-1];
            end
         end
      end
   end

   // prescale: quadrant fold into three cordic lanes
   function automatic q2e_pkg::cordic_vec_type prescale(
      input logic signed [W-1:0] y, input logic signed [W-1:0] x);
      q2e_pkg::cordic_vec_type v;
      if (x[W-1]) begin
         v.x = -x;
         v.y = -y;
         v.z = 32'h8000_0000;
      end else begin
         v.x = x;
         v.y = y;
         v.z = '0;
      end
      return v;
   endfunction

   q2e_pkg::cordic_vec_type lane_ff [3];
   logic zero_ff [3];
   logic clamp_p_ff, neg_p_ff;
   logic signed [W-1:0] cpitch;
   assign cpitch = W'(root_c[Sq]);
   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff[0] <= prescale(sr_d_ff[Sq-1], cr_d_ff[Sq-1]);
         lane_ff[1] <= prescale(s_d_ff[Sq-1], cpitch);
         lane_ff[2] <= prescale(sy_d_ff[Sq-1], cy_d_ff[Sq-1]);
         zero_ff[0] <= (sr_d_ff[Sq-1] == '0) && (cr_d_ff[Sq-1] == '0);
         zero_ff[1] <= (s_d_ff[Sq-1] == '0) && (cpitch == '0);
         zero_ff[2] <= (sy_d_ff[Sq-1] == '0) && (cy_d_ff[Sq-1] == '0);
         clamp_p_ff <= clamp_d_ff[Sq-1];
         neg_p_ff <= neg_d_ff[Sq-1];
      end
   end

   // cordic lanes
   q2e_pkg::cordic_vec_type vec_c [3][CORDIC_STAGES+1];
   logic zero_d_ff [3][CORDIC_STAGES];
   logic clamp_c_ff [CORDIC_STAGES];
   logic neg_c_ff [CORDIC_STAGES];

   for (genvar l = 0; l < 3; l++) begin : g_lane
      assign vec_c[l][0] = lane_ff[l];
      for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
         q2e_cordic_stage #(.STAGE(i)) u_stage (
            .clock(clock),
            .enable(enable),
            .vec_in(vec_c[l][i]),
            .vec_out(vec_c[l][i+1])
         );
         always_ff @(posedge clock) begin
            if (enable) begin
               zero_d_ff[l][i] <= (i == 0) ? zero_ff[l] : zero_d_ff[l][(i == 0) ? 0 : i-1];
            end
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_flag
      always_ff @(posedge clock) begin
         if (enable) begin
            clamp_c_ff[i] <= (i == 0) ? clamp_p_ff : clamp_c_ff[(i == 0) ? 0 : i-1];
            neg_c_ff[i] <= (i == 0) ? neg_p_ff : neg_c_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   // output register
   localparam int L = CORDIC_STAGES - 1;
   q2e_pkg::rsp_payload_type out_in;
   q2e_pkg::rsp_payload_type out_ff;
   always_comb begin
      out_in.roll_angle = zero_d_ff[0][L] ? 16'sd0
                          : q2e_pkg::to_angle16(vec_c[0][CORDIC_STAGES].z);
      out_in.yaw_angle = zero_d_ff[2][L] ? 16'sd0
                         : q2e_pkg::to_angle16(vec_c[2][CORDIC_STAGES].z);
      out_in.pitch_clamped = clamp_c_ff[L];
      if (clamp_c_ff[L]) begin
         out_in.pitch_angle = neg_c_ff[L] ? -16'sd16384 : 16'sd16384;
      end else if (zero_d_ff[1][L]) begin
         out_in.pitch_angle = 16'sd0;
      end else begin
         out_in.pitch_angle = q2e_pkg::to_angle16(vec_c[1][CORDIC_STAGES].z);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = valid_ff[Depth-1];
   assign rsp_payload = out_ff;

endmodule

/* rtl/q2e_cordic_stage.sv */
// one registered cordic vectoring micro-rotation
`timescale 1ns / 1ps
module q2e_cordic_stage #(
   parameter int STAGE = 0
) (
   input  logic clock,
   input  logic enable,
   input  q2e_pkg::cordic_vec_type vec_in,
   output q2e_pkg::cordic_vec_type vec_out
);

   q2e_pkg::cordic_vec_type vec_ff;
   q2e_pkg::cordic_vec_type vec_in_w;
   logic signed [q2e_pkg::DataWidth-1:0] dx;
   logic signed [q2e_pkg::DataWidth-1:0] dy;
   logic [q2e_pkg::AngleWidth-1:0] step;

   always_comb begin
      dx = vec_in.y >>> STAGE;
      dy = vec_in.x >>> STAGE;
      step = q2e_pkg::angle_table(5'(STAGE));
      if (!vec_in.y[q2e_pkg::DataWidth-1]) begin
         vec_in_w.x = vec_in.x + dx;
         vec_in_w.y = vec_in.y - dy;
         vec_in_w.z = vec_in.z + step;
      end else begin
         vec_in_w.x = vec_in.x - dx;
         vec_in_w.y = vec_in.y + dy;
         vec_in_w.z = vec_in.z - step;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in_w;
      end
   end

   assign vec_out = vec_ff;

endmodule

/* rtl/q2e_sqrt_stage.sv */
// one registered step of the restoring integer square root, two radicand bits and one root bit per step
`timescale 1ns / 1ps
module q2e_sqrt_stage #(
   parameter int STEP = 0
) (
   input  logic clock,
   input  logic enable,
   input  logic [q2e_pkg::SqrtInWidth-1:0] rem_in,
   input  logic [q2e_pkg::SqrtRootWidth-1:0] root_in,
   output logic [q2e_pkg::SqrtInWidth-1:0] rem_out,
   output logic [q2e_pkg::SqrtRootWidth-1:0] root_out
);

   localparam int Pos = 2 * (q2e_pkg::SqrtRootWidth - 1 - STEP);

   logic [q2e_pkg::SqrtInWidth-1:0] rem_ff;
   logic [q2e_pkg::SqrtRootWidth-1:0] root_ff;
   logic [q2e_pkg::SqrtInWidth+1:0] trial;
   logic [q2e_pkg::SqrtInWidth+1:0] rem_wide;
   logic [q2e_pkg::SqrtInWidth-1:0] rem_in_w;
   logic [q2e_pkg::SqrtRootWidth-1:0] root_in_w;

   // trial = (4*root + 1) << Pos, root holds the bits found so far
   always_comb begin
      trial = ((60'(root_in) << 2) | 60'd1) << Pos;
      rem_wide = 60'(rem_in);
      if (rem_wide >= trial) begin
         rem_in_w = q2e_pkg::SqrtInWidth'(rem_wide - trial);
         root_in_w = (root_in << 1) | 29'd1;
      end else begin
         rem_in_w = rem_in;
         root_in_w = root_in << 1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_w;
         root_ff <= root_in_w;
      end
   end

   assign rem_out = rem_ff;
   assign root_out = root_ff;

endmodule

/* test/quaternion_to_euler_angles_test.sv */
// testbench for the quaternion to euler angle converter: random and directed quaternions
`timescale 1ns / 1ps
module quaternion_to_euler_angles_test;

   localparam int CordicStages = 16;
   localparam int CycleLimit = 300000;
   localparam int RandomPerPhase = 250;
   localparam longint One = 64'sd1 <<< 28;

   localparam logic [31:0] AtanTable [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   q2e_pkg::req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   q2e_pkg::rsp_payload_type rsp_payload;

   q2e_pkg::req_payload_type pending_quats[$];
   q2e_pkg::rsp_payload_type expected_angles[$];
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int failures = 0;
   int cycles = 0;

   quaternion_to_euler_angles #(.CORDIC_STAGES(CordicStages)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [31:0] vector_angle(longint y, longint x);
      logic [31:0] z;
      longint dx;
      longint dy;
      z = '0;
      if (x == 0 && y == 0) begin
         return '0;
      end
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (int i = 0; i < CordicStages; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x = x + dx;
            y = y - dy;
            z = z + AtanTable[i];
         end else begin
            x = x - dx;
            y = y + dy;
            z = z - AtanTable[i];
         end
      end
      return z;
   endfunction

   function automatic logic [15:0] round_angle(logic [31:0] z);
      logic [31:0] t;
      t = z + 32'h0000_8000;
      return t[31:16];
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitval;
      root = 0;
      bitval = 64'd1 << 62;
      while (bitval > v) bitval = bitval >> 2;
      while (bitval != 0) begin
         if (v >= root + bitval) begin
            v = v - (root + bitval);
            root = (root >> 1) + bitval;
         end else begin
            root = root >> 1;
         end
         bitval = bitval >> 2;
      end
      return root;
   endfunction

   function automatic q2e_pkg::rsp_payload_type euler_angles(q2e_pkg::req_payload_type q);
      q2e_pkg::rsp_payload_type r;
      longint w;
      longint x;
      longint y;
      longint zq;
      longint sr;
      longint cr;
      longint sy;
      longint cy;
      longint s;
      longint unsigned rem;
      longint c;
      w = q.quat_w;
      x = q.quat_x;
      y = q.quat_y;
      zq = q.quat_z;
      sr = 2 * (w * x + y * zq);
      cr = One - 2 * (x * x + y * y);
      sy = 2 * (w * zq + x * y);
      cy = One - 2 * (y * y + zq * zq);
      s = 2 * (w * y - zq * x);
      if (s >= One) begin
         r.pitch_angle = 16'sd16384;
         r.pitch_clamped = 1'b1;
      end else if (s <= -One) begin
         r.pitch_angle = -16'sd16384;
         r.pitch_clamped = 1'b1;
      end else begin
         rem = (64'd1 << 56) - longint'(s * s);
         c = longint'(floor_sqrt(rem));
         r.pitch_angle = round_angle(vector_angle(s, c));
         r.pitch_clamped = 1'b0;
      end
      r.roll_angle = round_angle(vector_angle(sr, cr));
      r.yaw_angle = round_angle(vector_angle(sy, cy));
      return r;
   endfunction

   function automatic q2e_pkg::req_payload_type make_quat(int w, int x, int y, int z);
      q2e_pkg::req_payload_type q;
      q.quat_w = 16'(w);
      q.quat_x = 16'(x);
      q.quat_y = 16'(y);
      q.quat_z = 16'(z);
      return q;
   endfunction

   function automatic int clip_q14(int v);
      if (v > 16384) return 16384;
      if (v < -16384) return -16384;
      return v;
   endfunction

   function automatic int uniform_q14();
      return $urandom_range(32768) - 16384;
   endfunction

   function automatic q2e_pkg::req_payload_type random_quat();
      real c[4];
      real norm;
      int kind;
      int g;
      kind = $urandom_range(99);
      if (kind < 25) begin
         return make_quat(uniform_q14(), uniform_q14(), uniform_q14(), uniform_q14());
      end else if (kind < 40) begin
         // near gimbal lock, w and y close to +-1/sqrt2
         g = ($urandom_range(1) ? 11585 : -11585) + $urandom_range(20) - 10;
         return make_quat(clip_q14(g), $urandom_range(20) - 10,
                          clip_q14(($urandom_range(1) ? g : -g) + $urandom_range(6) - 3),
                          $urandom_range(20) - 10);
      end
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
         c[i] = (real'($urandom_range(200000)) - 100000.0) / 100000.0;
         norm = norm + c[i] * c[i];
      end
      if (norm < 1.0e-6) begin
         return make_quat(16384, 0, 0, 0);
      end
      norm = $sqrt(norm);
      return make_quat(clip_q14($rtoi(c[0] / norm * 16384.0)),
                       clip_q14($rtoi(c[1] / norm * 16384.0)),
                       clip_q14($rtoi(c[2] / norm * 16384.0)),
                       clip_q14($rtoi(c[3] / norm * 16384.0)));
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_angles.push_back(euler_angles(req_payload));
         end
         if (!req_valid || !req_stall) begin
            if (pending_quats.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_payload <= pending_quats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      q2e_pkg::rsp_payload_type exp_r;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_angles.size() == 0) begin
               $error("unexpected transaction roll %0d pitch %0d yaw %0d",
                      rsp_payload.roll_angle, rsp_payload.pitch_angle,
                      rsp_payload.yaw_angle);
               failures++;
            end else begin
               exp_r = expected_angles.pop_front();
               if (rsp_payload.roll_angle !== exp_r.roll_angle) begin
                  $error("roll_angle expected %0d got %0d",
                         exp_r.roll_angle, rsp_payload.roll_angle);
                  failures++;
               end
               if (rsp_payload.pitch_angle !== exp_r.pitch_angle) begin
                  $error("pitch_angle expected %0d got %0d",
                         exp_r.pitch_angle, rsp_payload.pitch_angle);
                  failures++;
               end
               if (rsp_payload.yaw_angle !== exp_r.yaw_angle) begin
                  $error("yaw_angle expected %0d got %0d",
                         exp_r.yaw_angle, rsp_payload.yaw_angle);
                  failures++;
               end
               if (rsp_payload.pitch_clamped !== exp_r.pitch_clamped) begin
                  $error("pitch_clamped expected %0d got %0d",
                         exp_r.pitch_clamped, rsp_payload.pitch_clamped);
                  failures++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      pending_quats.push_back(make_quat(0, 0, 0, 0));
      pending_quats.push_back(make_quat(16384, 0, 0, 0));
      pending_quats.push_back(make_quat(-16384, 0, 0, 0));
      pending_quats.push_back(make_quat(0, 16384, 0, 0));
      pending_quats.push_back(make_quat(0, 0, 16384, 0));
      pending_quats.push_back(make_quat(0, 0, 0, 16384));
      pending_quats.push_back(make_quat(0, 0, 0, -16384));
      pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
      pending_quats.push_back(make_quat(-16384, -16384, -16384, -16384));
      pending_quats.push_back(make_quat(16384, -16384, 16384, -16384));
      pending_quats.push_back(make_quat(16384, 0, 16384, 0));
      pending_quats.push_back(make_quat(16384, 0, -16384, 0));
      pending_quats.push_back(make_quat(11585, 0, 11585, 0));
      pending_quats.push_back(make_quat(11585, 0, -11585, 0));
      pending_quats.push_back(make_quat(11586, 0, 11586, 0));
      pending_quats.push_back(make_quat(0, 8192, 8192, 0));
      pending_quats.push_back(make_quat(0, 0, 8192, 8192));
      pending_quats.push_back(make_quat(0, -16384, 0, 0));
      pending_quats.push_back(make_quat(1, -1, 1, -1));
      pending_quats.push_back(make_quat(-1, 16384, -16384, 1));

      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 60; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 60; end
            default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
         endcase
         for (int i = 0; i < RandomPerPhase; i++) pending_quats.push_back(random_quat());
         // drain completely before the next phase
         while (pending_quats.size() > 0 || req_valid || expected_angles.size() > 0)
            @(posedge clock);
      end

      repeat (100) @(posedge clock);
      if (failures == 0 && expected_angles.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
